// ----- hdl/eas_pkg.sv -----
// Shared types and constants for the two-knob setpoint unit with acceleration.
// Used by eas_update and the top level; depends on nothing.
package eas_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_FAST_THRESHOLD = 3'd0,
    CFG_WINDOW_TICKS   = 3'd1,
    CFG_TIME_CAP       = 3'd2,
    CFG_TIME_FLOOR     = 3'd3,
    CFG_SPEED_CAP      = 3'd4,
    CFG_SPEED_FLOOR    = 3'd5
  } cfg_reg_t;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 17;

  // Register reset values
  localparam logic [15:0] FAST_THRESHOLD_RST = 16'd10;
  localparam logic [15:0] WINDOW_TICKS_RST   = 16'd1000;
  localparam logic [16:0] TIME_CAP_RST       = 17'd86400;
  localparam logic [16:0] TIME_FLOOR_RST     = 17'd60;
  localparam logic [15:0] SPEED_CAP_RST      = 16'd1500;
  localparam logic [15:0] SPEED_FLOOR_RST    = 16'd100;

  // Step sizes
  localparam logic [16:0] TIME_STEP_FINE    = 17'd60;
  localparam logic [16:0] TIME_STEP_COARSE  = 17'd600;
  localparam logic [15:0] SPEED_STEP_FINE   = 16'd5;
  localparam logic [15:0] SPEED_STEP_COARSE = 16'd50;

  // Program number range and edge count ceiling
  localparam logic [3:0]  PROG_FIRST = 4'd1;
  localparam logic [3:0]  PROG_LAST  = 4'd9;
  localparam logic [15:0] EDGE_SAT   = 16'hFFFF;

  // Input item codes
  localparam logic FUNC_TICK = 1'b0;
  localparam logic KNOB_TIME = 1'b0;

  typedef struct packed {
    logic [15:0] fast_threshold;
    logic [15:0] window_ticks;
    logic [16:0] time_cap;
    logic [16:0] time_floor;
    logic [15:0] speed_cap;
    logic [15:0] speed_floor;
  } cfg_t;

  typedef struct packed {
    logic func;
    logic knob;
    logic phase_b_level;
    logic param_mode;
  } item_t;

  typedef struct packed {
    logic [15:0]       tick_counter;
    logic [1:0][15:0]  edge_count;
    logic [1:0][15:0]  rate_latch;
    logic [16:0]       time_value;
    logic [15:0]       speed_value;
    logic [3:0]        program_value;
  } state_t;

  typedef struct packed {
    logic [16:0] time_setpoint;
    logic [15:0] speed_setpoint;
    logic [3:0]  program_number;
    logic        time_blink;
    logic        speed_blink;
    logic        param_reload;
  } result_t;

endpackage

// ----- hdl/eas_update.sv -----
// Next-state and result logic for one tick or detent edge transaction.
// Depends on eas_pkg for the state, item, configuration and result types.
module eas_update (
  input  eas_pkg::state_t  st,
  input  eas_pkg::cfg_t    cfg,
  input  eas_pkg::item_t   item,
  output eas_pkg::state_t  st_next,
  output eas_pkg::result_t res
);

  logic [15:0] tick_inc;
  logic        window_end;
  logic        fast;
  logic [16:0] time_step;
  logic [16:0] time_diff;
  logic [17:0] time_sum;
  logic [15:0] speed_step;
  logic [15:0] speed_diff;
  logic [16:0] speed_sum;

  // Shared arithmetic
  assign tick_inc   = st.tick_counter + 16'd1;
  assign window_end = (tick_inc == 16'd0) || (tick_inc >= cfg.window_ticks);
  assign fast       = st.rate_latch[item.knob] >= cfg.fast_threshold;
  assign time_step  = fast ? eas_pkg::TIME_STEP_COARSE : eas_pkg::TIME_STEP_FINE;
  assign time_diff  = st.time_value - time_step;
  assign time_sum   = {1'b0, st.time_value} + {1'b0, time_step};
  assign speed_step = fast ? eas_pkg::SPEED_STEP_COARSE : eas_pkg::SPEED_STEP_FINE;
  assign speed_diff = st.speed_value - speed_step;
  assign speed_sum  = {1'b0, st.speed_value} + {1'b0, speed_step};

  // Advance the state for one transaction
  always_comb begin
    st_next         = st;
    res.time_blink  = 1'b0;
    res.speed_blink = 1'b0;
    res.param_reload = 1'b0;
    if (item.func == eas_pkg::FUNC_TICK) begin
      // Close the window when it ends: latch rates and restart counts; else count the tick
      if (window_end) begin
        st_next.rate_latch   = st.edge_count;
        st_next.edge_count   = '0;
        st_next.tick_counter = '0;
      end else begin
        st_next.tick_counter = tick_inc;
      end
    end else begin
      // Count the edge, saturating
      if (st.edge_count[item.knob] != eas_pkg::EDGE_SAT) begin
        st_next.edge_count[item.knob] = st.edge_count[item.knob] + 16'd1;
      end
      if (item.param_mode) begin
        if (item.phase_b_level) begin
          st_next.program_value = (st.program_value <= eas_pkg::PROG_FIRST) ?
                                  eas_pkg::PROG_LAST : st.program_value - 4'd1;
        end else begin
          st_next.program_value = (st.program_value >= eas_pkg::PROG_LAST) ?
                                  eas_pkg::PROG_FIRST : st.program_value + 4'd1;
        end
        res.param_reload = 1'b1;
      end else if (item.knob == eas_pkg::KNOB_TIME) begin
        if (item.phase_b_level) begin
          // Drop to zero below the minimum
          if ((st.time_value < time_step) || (time_diff < cfg.time_floor)) begin
            st_next.time_value = '0;
          end else begin
            st_next.time_value = time_diff;
          end
        end else begin
          st_next.time_value = (time_sum > {1'b0, cfg.time_cap}) ?
                               cfg.time_cap : time_sum[16:0];
        end
        res.time_blink = 1'b1;
      end else begin
        if (item.phase_b_level) begin
          if ((st.speed_value < speed_step) || (speed_diff < cfg.speed_floor)) begin
            st_next.speed_value = cfg.speed_floor;
          end else begin
            st_next.speed_value = speed_diff;
          end
        end else begin
          st_next.speed_value = (speed_sum > {1'b0, cfg.speed_cap}) ?
                                cfg.speed_cap : speed_sum[15:0];
        end
        res.speed_blink = 1'b1;
      end
    end
    res.time_setpoint  = st_next.time_value;
    res.speed_setpoint = st_next.speed_value;
    res.program_number = st_next.program_value;
  end

endmodule

// ----- hdl/encoder_accelerated_setpoint_unit.sv -----
// Top level of the two-knob setpoint unit with rotation-rate acceleration.
// Depends on eas_pkg and eas_update.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one transaction per task tick
//   or detent edge: func, knob, phase_b_level, param_mode.
//   Output channel (out_valid / out_stall) returns one result per input:
//   the three setpoints and the blink / reload flags for that transaction.
//   Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes
//   one of six registers; cfg_ready is always high. Write only while idle.
// Timing:
//   The path runs through the input register, then the update logic into
//   the result register. One transaction is accepted every cycle while no
//   out_stall holds the result; the rate is set by the state update between those registers.
// Reset:
//   rst (synchronous) empties both stages, loads the register defaults and
//   clears the rate counters; speed starts at 100, program number at 1.
// Stall:
//   A stalled result holds in the result register; the input register keeps
//   its transaction and raises in_stall until the result register frees.
module encoder_accelerated_setpoint_unit (
  input  logic                           clk,
  input  logic                           rst,
  // Input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           func,
  input  logic                           knob,
  input  logic                           phase_b_level,
  input  logic                           param_mode,
  // Output channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [16:0]                    time_setpoint,
  output logic [15:0]                    speed_setpoint,
  output logic [3:0]                     program_number,
  output logic                           time_blink,
  output logic                           speed_blink,
  output logic                           param_reload,
  // Configuration channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [eas_pkg::CfgIndexW-1:0]  cfg_index,
  input  logic [eas_pkg::CfgDataW-1:0]   cfg_data
);

  eas_pkg::cfg_t    cfg;
  eas_pkg::state_t  st;
  eas_pkg::state_t  st_next;
  eas_pkg::item_t   item;
  eas_pkg::result_t res_next;
  eas_pkg::result_t res;
  logic             item_valid;
  logic             in_take;
  logic             load_out;

  // Handshake
  assign load_out  = item_valid && (!out_valid || !out_stall);
  assign in_stall  = item_valid && !load_out;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fast_threshold <= eas_pkg::FAST_THRESHOLD_RST;
      cfg.window_ticks   <= eas_pkg::WINDOW_TICKS_RST;
      cfg.time_cap       <= eas_pkg::TIME_CAP_RST;
      cfg.time_floor     <= eas_pkg::TIME_FLOOR_RST;
      cfg.speed_cap      <= eas_pkg::SPEED_CAP_RST;
      cfg.speed_floor    <= eas_pkg::SPEED_FLOOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        eas_pkg::CFG_FAST_THRESHOLD: cfg.fast_threshold <= cfg_data[15:0];
        eas_pkg::CFG_WINDOW_TICKS:   cfg.window_ticks   <= cfg_data[15:0];
        eas_pkg::CFG_TIME_CAP:       cfg.time_cap       <= cfg_data;
        eas_pkg::CFG_TIME_FLOOR:     cfg.time_floor     <= cfg_data;
        eas_pkg::CFG_SPEED_CAP:      cfg.speed_cap      <= cfg_data[15:0];
        eas_pkg::CFG_SPEED_FLOOR:    cfg.speed_floor    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Input register: hold the transaction until the result register frees
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_take) begin
      item_valid <= 1'b1;
    end else if (load_out) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item <= '{func: func, knob: knob, phase_b_level: phase_b_level,
                param_mode: param_mode};
    end
  end

  eas_update u_update (
    .st      (st),
    .cfg     (cfg),
    .item    (item),
    .st_next (st_next),
    .res     (res_next)
  );

  // Setpoint and rate state: advance when a result is loaded
  always_ff @(posedge clk) begin
    if (rst) begin
      st.tick_counter  <= '0;
      st.edge_count    <= '0;
      st.rate_latch    <= '0;
      st.time_value    <= '0;
      st.speed_value   <= eas_pkg::SPEED_FLOOR_RST;
      st.program_value <= eas_pkg::PROG_FIRST;
    end else if (load_out) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res <= res_next;
    end
  end

  assign time_setpoint  = res.time_setpoint;
  assign speed_setpoint = res.speed_setpoint;
  assign program_number = res.program_number;
  assign time_blink     = res.time_blink;
  assign speed_blink    = res.speed_blink;
  assign param_reload   = res.param_reload;

endmodule

// ----- hdl/eas_checker.sv -----
// Port-level checks for the setpoint unit, attached by the bind below.
// Depends only on the top level's ports.
module eas_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [16:0] time_setpoint,
  input logic [15:0] speed_setpoint,
  input logic [3:0]  program_number,
  input logic        time_blink,
  input logic        speed_blink,
  input logic        param_reload
);

  // Result channel is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result stays
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  // A stalled result keeps its setpoints
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(time_setpoint) && $stable(speed_setpoint)
      && $stable(program_number))
    else $error("stalled result changed");

  // Program number stays within its wrap range
  a_prog_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (program_number >= 4'd1) && (program_number <= 4'd9))
    else $error("program number out of range");

  // At most one adjustment flag per transaction
  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({time_blink, speed_blink, param_reload}))
    else $error("several adjustment flags raised");

endmodule

bind encoder_accelerated_setpoint_unit eas_checker u_eas_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .time_setpoint  (time_setpoint),
  .speed_setpoint (speed_setpoint),
  .program_number (program_number),
  .time_blink     (time_blink),
  .speed_blink    (speed_blink),
  .param_reload   (param_reload)
);
